[design/sipq_pkg.sv]
// Shared types and constants for the sorted-insert priority queue.
// No dependencies; used by sipq_cell and sorted_insert_priority_queue.
`default_nettype none

package sipq_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned PRIO_W  = 3;
    localparam int unsigned OCC_W   = 8;

    localparam logic [PRIO_W-1:0] MAX_PRIO = 3'd5;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } entry_t;

    // Broadcast from the top level to every cell in the chain.
    typedef struct packed {
        logic   enq;       // accepted enqueue that stores an entry
        logic   deq;       // accepted dequeue that removes the front entry
        entry_t new_entry; // entry being inserted
    } cell_ctrl_t;

endpackage

`default_nettype wire

[design/sipq_cell.sv]
// One storage cell of the sorted-insert priority queue chain.
// Depends on sipq_pkg for the entry and control types.
`default_nettype none

module sipq_cell #(
    parameter int unsigned IDX     = 0,
    parameter int unsigned COUNT_W = 8
) (
    input  wire logic                  aclk,
    input  wire sipq_pkg::cell_ctrl_t  ctrl,
    input  wire logic [COUNT_W-1:0]    count,
    input  wire sipq_pkg::entry_t      left_entry,
    input  wire logic                  left_gt,
    input  wire sipq_pkg::entry_t      right_entry,
    output sipq_pkg::entry_t           entry,
    output logic                       gt
);

    sipq_pkg::entry_t entry_reg;
    sipq_pkg::entry_t entry_next;
    logic             occupied;
    logic             less_urgent;

    assign occupied    = count > COUNT_W'(IDX);
    assign less_urgent = entry_reg.prio > ctrl.new_entry.prio;
    assign gt          = occupied && less_urgent;

    // On insert: take the left neighbor if it moves back, else take the new
    // entry if this slot is free or less urgent, else hold. On removal: advance.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.enq) begin
            if (left_gt) begin
                entry_next = left_entry;
            end else if (!occupied || less_urgent) begin
                entry_next = ctrl.new_entry;
            end
        end else if (ctrl.deq) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

[design/sorted_insert_priority_queue.sv]
// Top level of the sorted-insert priority queue: a chain of sipq_cell slots
// plus count, status decode and the result register. Depends on sipq_pkg.
//
// Usage: one beat on the s_axis channel is one operation; tuser[0] is the
// opcode (0 enqueue, 1 dequeue), tdata carries value and priority. Every
// operation returns exactly one beat on the m_axis channel with a status in
// tuser, the dequeued value and priority (zero otherwise) and the occupancy
// after the operation. Priority 0 is most urgent; equal priorities leave in
// arrival order.
// Timing: the result is registered and shown in the cycle after the input beat
// is taken. Throughput: one operation per cycle when not stalled. Every cell
// compares its priority to the incoming one and shifts in parallel, so an
// insert or a removal is done in the cycle that loads the result register.
// Stall: when the receiver holds m_axis_tready low the result register keeps
// its beat and s_axis_tready drops until that beat is taken; s_axis_tready is
// high whenever the result register is empty or being drained that cycle.
// Reset: aresetn (synchronous, active low) empties the queue by clearing the
// count, drops m_axis_tvalid and holds s_axis_tready low. Cell contents are
// not cleared; slots at or beyond the count are never read, so no clearing
// pass is needed.
`default_nettype none

module sorted_insert_priority_queue #(
    parameter int unsigned DEPTH = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // [31:0] value_in, [34:32] priority_in, [39:35] zero
    input  wire logic [0:0]  s_axis_tuser,  // [0] opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // [31:0] value_out, [34:32] priority_out,
                                            // [42:35] occupancy, [47:43] zero
    output logic [1:0]       m_axis_tuser   // [1:0] status
);

    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

    // Input beat fields
    logic                                   opcode;
    logic signed [sipq_pkg::VALUE_W-1:0]    value_in;
    logic [sipq_pkg::PRIO_W-1:0]            priority_in;

    assign opcode      = s_axis_tuser[0];
    assign value_in    = s_axis_tdata[31:0];
    assign priority_in = s_axis_tdata[34:32];

    logic s_accept;
    logic m_accept;

    // Queue occupancy
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    // Result register
    logic                                m_tvalid_reg;
    logic                                m_tvalid_next;
    logic [1:0]                          status_reg;
    logic [1:0]                          status_next;
    logic signed [sipq_pkg::VALUE_W-1:0] value_out_reg;
    logic signed [sipq_pkg::VALUE_W-1:0] value_out_next;
    logic [sipq_pkg::PRIO_W-1:0]         prio_out_reg;
    logic [sipq_pkg::PRIO_W-1:0]         prio_out_next;
    logic [sipq_pkg::OCC_W-1:0]          occ_reg;
    logic [sipq_pkg::OCC_W-1:0]          occ_next;
    logic [COUNT_W+sipq_pkg::OCC_W-1:0]  count_ext;

    // Cell chain
    sipq_pkg::cell_ctrl_t ctrl;
    sipq_pkg::entry_t     cell_entry [DEPTH];
    logic                 cell_gt    [DEPTH];

    logic is_full;
    logic is_empty;

    assign m_accept      = m_tvalid_reg && m_axis_tready;
    assign s_axis_tready = aresetn && (!m_tvalid_reg || m_axis_tready);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign is_full  = count_reg == COUNT_W'(DEPTH);
    assign is_empty = count_reg == '0;

    // Decode the operation; fullness is checked before the priority.
    always_comb begin
        status_next    = sipq_pkg::ST_OK;
        value_out_next = '0;
        prio_out_next  = '0;
        count_next     = count_reg;
        ctrl.enq       = 1'b0;
        ctrl.deq       = 1'b0;
        ctrl.new_entry.value = value_in;
        ctrl.new_entry.prio  = priority_in;
        if (opcode == sipq_pkg::OP_ENQUEUE) begin
            if (is_full) begin
                status_next = sipq_pkg::ST_OVERFLOW;
            end else if (priority_in > sipq_pkg::MAX_PRIO) begin
                status_next = sipq_pkg::ST_INVALID;
            end else begin
                ctrl.enq   = s_accept;
                count_next = count_reg + COUNT_W'(1);
            end
        end else begin
            if (is_empty) begin
                status_next = sipq_pkg::ST_UNDERFLOW;
            end else begin
                ctrl.deq       = s_accept;
                value_out_next = cell_entry[0].value;
                prio_out_next  = cell_entry[0].prio;
                count_next     = count_reg - COUNT_W'(1);
            end
        end
    end

    // Occupancy reports the low byte of the new count.
    assign count_ext = {{sipq_pkg::OCC_W{1'b0}}, count_next};
    assign occ_next  = count_ext[sipq_pkg::OCC_W-1:0];

    // Build the chain: each slot talks to its neighbors; the head's left is the new entry.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        sipq_pkg::entry_t left_entry;
        logic             left_gt;
        sipq_pkg::entry_t right_entry;

        if (i == 0) begin : g_head
            assign left_entry = ctrl.new_entry;
            assign left_gt    = 1'b0;
        end else begin : g_mid_l
            assign left_entry = cell_entry[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        // The tail slot has no right neighbor; what it loads on removal lies
        // beyond the new count and is never read.
        if (i == DEPTH - 1) begin : g_tail
            assign right_entry = cell_entry[i];
        end else begin : g_mid_r
            assign right_entry = cell_entry[i+1];
        end

        sipq_cell #(
            .IDX     (i),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_entry  (left_entry),
            .left_gt     (left_gt),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
        );
    end

    // Hold the result until taken; drop valid once drained with no new beat.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_accept) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (s_accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            status_reg    <= status_next;
            value_out_reg <= value_out_next;
            prio_out_reg  <= prio_out_next;
            occ_reg       <= occ_next;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {5'd0, occ_reg, prio_out_reg, value_out_reg};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(DEPTH))
        else $error("count exceeds depth");

    a_enq_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.enq |=> count_reg == $past(count_reg) + COUNT_W'(1))
        else $error("insert did not grow the count");

    a_deq_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.deq |=> count_reg == $past(count_reg) - COUNT_W'(1))
        else $error("removal did not shrink the count");

    a_front_prio: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && status_reg == sipq_pkg::ST_OK) |-> prio_out_reg <= sipq_pkg::MAX_PRIO)
        else $error("front entry has an invalid priority");

    a_underflow_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && status_reg == sipq_pkg::ST_UNDERFLOW)
            |-> (value_out_reg == '0 && prio_out_reg == '0 && occ_reg == '0))
        else $error("underflow result carries data");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking bench for the sorted-insert priority queue: directed, fill/overflow,
// back-pressure and random tests against an in-bench model of the sorted contents.
// Depends on sipq_pkg and sorted_insert_priority_queue.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUEUE_DEPTH = 128;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned DEFAULT_GAP = 12;

    // Expected outcome of one operation, one per accepted input beat.
    typedef struct {
        logic [1:0]                   status;
        logic [sipq_pkg::VALUE_W-1:0] value;
        logic [sipq_pkg::PRIO_W-1:0]  prio;
        logic [sipq_pkg::OCC_W-1:0]   occupancy;
    } queue_result_t;

    // Receiver back-pressure styles, switched per segment.
    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_e;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;  // [31:0] value_in, [34:32] priority_in, [39:35] zero
    logic [0:0]  s_axis_tuser  = '0;  // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // [31:0] value_out, [34:32] priority_out,
                                      // [42:35] occupancy, [47:43] zero
    logic [1:0]  m_axis_tuser;        // [1:0] status

    sipq_pkg::entry_t sorted_contents[$];  // model of the stored entries, front first
    queue_result_t    pending_results[$];  // outcomes still owed by the block
    int               error_count = 0;

    // sender burst state
    int burst_left = 0;
    int gap_limit  = DEFAULT_GAP;

    // receiver state; hold_request is set by a test and taken by the receiver
    int       hold_request   = 0;
    int       hold_left      = 0;
    int       stall_seg_left = 0;
    rx_mode_e stall_mode     = RX_ALWAYS;
    logic [7:0] stall_pattern = 8'hff;

    sorted_insert_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Apply one operation to the model and return what the block must report.
    function automatic queue_result_t apply_queue_op(logic op,
                                                     logic [sipq_pkg::VALUE_W-1:0] val,
                                                     logic [sipq_pkg::PRIO_W-1:0] prio);
        queue_result_t    res;
        sipq_pkg::entry_t slot;
        int               pos;
        res.status = sipq_pkg::ST_OK;
        res.value  = '0;
        res.prio   = '0;
        if (op == sipq_pkg::OP_ENQUEUE) begin
            if (sorted_contents.size() >= QUEUE_DEPTH) begin
                // fullness wins over a bad priority
                res.status = sipq_pkg::ST_OVERFLOW;
            end else if (prio > sipq_pkg::MAX_PRIO) begin
                res.status = sipq_pkg::ST_INVALID;
            end else begin
                // land behind every entry of equal or more urgent priority
                pos = sorted_contents.size();
                while (pos > 0 && sorted_contents[pos-1].prio > prio)
                    pos--;
                slot.value = val;
                slot.prio  = prio;
                sorted_contents.insert(pos, slot);
            end
        end else if (sorted_contents.size() == 0) begin
            res.status = sipq_pkg::ST_UNDERFLOW;
        end else begin
            slot      = sorted_contents.pop_front();
            res.value = slot.value;
            res.prio  = slot.prio;
        end
        res.occupancy = sipq_pkg::OCC_W'(sorted_contents.size());
        return res;
    endfunction

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    // Check result beats first, then record the outcome of any input beat taken
    // at the same edge; a result is registered, so it always trails its input.
    always @(posedge aclk) begin : scoreboard
        queue_result_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result beat, expected none, actual %0h/%0h",
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = pending_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(m_axis_tuser));
                    compare_field("value_out", want.value, m_axis_tdata[31:0]);
                    compare_field("priority_out", 32'(want.prio), 32'(m_axis_tdata[34:32]));
                    compare_field("occupancy", 32'(want.occupancy),
                                  32'(m_axis_tdata[42:35]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(apply_queue_op(s_axis_tuser[0], s_axis_tdata[31:0],
                                                         s_axis_tdata[34:32]));
        end
    end

    // Receiver: honor a requested hold-off first, otherwise stall per segment mode.
    always @(posedge aclk) begin : receiver
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (stall_seg_left == 0) begin
                stall_mode     = rx_mode_e'($urandom_range(RX_SPARSE, RX_ALWAYS));
                stall_seg_left = $urandom_range(300, 20);
                stall_pattern  = 8'($urandom());
            end
            stall_seg_left--;
            stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
            case (stall_mode)
                RX_ALWAYS:  m_axis_tready <= 1'b1;
                RX_RANDOM:  m_axis_tready <= 1'($urandom_range(1, 0));
                RX_PATTERN: m_axis_tready <= stall_pattern[0];
                default:    m_axis_tready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    // Offer one beat and hold it until taken; may open a gap between bursts.
    task automatic send_op(logic op, logic [sipq_pkg::VALUE_W-1:0] val,
                           logic [sipq_pkg::PRIO_W-1:0] prio);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_limit == 0 || $urandom_range(2, 0) == 0) ? 0
                : $urandom_range(gap_limit, 1);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(40, 1);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, prio, val};
        s_axis_tuser  <= op;
        do @(posedge aclk); while (s_axis_tready !== 1'b1);
    endtask

    function automatic logic [sipq_pkg::VALUE_W-1:0] random_value();
        case ($urandom_range(19, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [sipq_pkg::PRIO_W-1:0] random_prio(int invalid_pct);
        if ($urandom_range(99, 0) < invalid_pct)
            return sipq_pkg::PRIO_W'($urandom_range(7, 6));
        return sipq_pkg::PRIO_W'($urandom_range(sipq_pkg::MAX_PRIO, 0));
    endfunction

    // Extremes, invalid priorities, underflow and FIFO order within a priority.
    task automatic test_directed();
        send_op(sipq_pkg::OP_DEQUEUE, 32'hdead_beef, 3'd7);
        send_op(sipq_pkg::OP_ENQUEUE, 32'h1234_5678, 3'd7);
        send_op(sipq_pkg::OP_ENQUEUE, 32'hffff_ffff, 3'd6);
        send_op(sipq_pkg::OP_ENQUEUE, 32'h7fff_ffff, 3'd5);
        send_op(sipq_pkg::OP_ENQUEUE, 32'h8000_0000, 3'd0);
        send_op(sipq_pkg::OP_ENQUEUE, 32'hffff_ffff, 3'd5);
        send_op(sipq_pkg::OP_ENQUEUE, 32'h0000_0000, 3'd3);
        send_op(sipq_pkg::OP_ENQUEUE, 32'h5555_5555, 3'd3);
        send_op(sipq_pkg::OP_ENQUEUE, 32'haaaa_aaaa, 3'd0);
        repeat (6) send_op(sipq_pkg::OP_DEQUEUE, $urandom(), 3'($urandom_range(7, 0)));
        send_op(sipq_pkg::OP_DEQUEUE, 32'hffff_ffff, 3'd7);
        // refill the empty queue; the last insert goes ahead of both stored entries
        send_op(sipq_pkg::OP_ENQUEUE, 32'h0000_0002, 3'd2);
        send_op(sipq_pkg::OP_ENQUEUE, 32'h0000_0004, 3'd4);
        send_op(sipq_pkg::OP_ENQUEUE, 32'h0000_0001, 3'd1);
        repeat (3) send_op(sipq_pkg::OP_DEQUEUE, 32'h0, 3'd0);
    endtask

    // Fill to the brim, hit overflow with good and bad priorities, drain to empty, then underflow.
    task automatic test_fill_overflow();
        repeat (QUEUE_DEPTH) send_op(sipq_pkg::OP_ENQUEUE, random_value(), random_prio(0));
        send_op(sipq_pkg::OP_ENQUEUE, $urandom(), 3'd3);
        send_op(sipq_pkg::OP_ENQUEUE, $urandom(), 3'd7);
        send_op(sipq_pkg::OP_ENQUEUE, $urandom(), 3'd0);
        repeat (QUEUE_DEPTH)
            send_op(sipq_pkg::OP_DEQUEUE, $urandom(), 3'($urandom_range(7, 0)));
        send_op(sipq_pkg::OP_DEQUEUE, $urandom(), 3'd0);
    endtask

    // Hold the receiver off for a long stretch while beats keep coming.
    task automatic test_backpressure();
        hold_request = 400;
        gap_limit    = 0;
        burst_left   = 0;
        repeat (40)
            send_op($urandom_range(99, 0) < 60 ? sipq_pkg::OP_ENQUEUE : sipq_pkg::OP_DEQUEUE,
                    random_value(), random_prio(10));
        gap_limit = DEFAULT_GAP;
    endtask

    // Random mixes; the enqueue share swings per phase so occupancy rises and falls.
    task automatic test_random();
        int enq_share[10] = '{80, 50, 20, 95, 60, 10, 70, 40, 90, 30};
        foreach (enq_share[p])
            repeat (70)
                send_op($urandom_range(99, 0) < enq_share[p] ? sipq_pkg::OP_ENQUEUE
                                                             : sipq_pkg::OP_DEQUEUE,
                        random_value(), random_prio(8));
    endtask

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin : main
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_fill_overflow();
        test_backpressure();
        test_random();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
design/sipq_pkg.sv
design/sipq_cell.sv
design/sorted_insert_priority_queue.sv
tb/sv/tb_top.sv
